[hw/rtl/hdec_pkg.sv]
`timescale 1ns / 1ps
package hdec_pkg;

  localparam int NODE_COUNT = 512;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 8;
  localparam int TOP_BIT    = 7;
  localparam int BIT_W      = $clog2(CODE_W);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] symbol;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_LOOK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    logic [SYM_W-1:0] symbol;
  } emit_ctl_t;

endpackage

[hw/rtl/hdec_in_if.sv]
`timescale 1ns / 1ps
interface hdec_in_if import hdec_pkg::*;;
  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             leaf_flag;
  logic [SYM_W-1:0] symbol_value;
  logic [CODE_W-1:0] code_byte;
  logic             final_byte;

  modport source (
    output valid, command, node_index, left_child, right_child, leaf_flag,
           symbol_value, code_byte, final_byte,
    input  ready
  );

  modport sink (
    input  valid, command, node_index, left_child, right_child, leaf_flag,
           symbol_value, code_byte, final_byte,
    output ready
  );
endinterface

[hw/rtl/hdec_out_if.sv]
`timescale 1ns / 1ps
interface hdec_out_if import hdec_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] decoded_symbol;
  logic             last_of_byte;

  modport source (
    output valid, decoded_symbol, last_of_byte,
    input  ready
  );

  modport sink (
    input  valid, decoded_symbol, last_of_byte,
    output ready
  );
endinterface

[hw/rtl/huffman_tree_decoder_top.sv]
`timescale 1ns / 1ps
// Node write word: taken while idle, and the block is ready again the next cycle.
// Decode word: from acceptance until ready again the walk makes a step and a leaf check per
// code bit, then a closing flush, since each bit needs one registered read of the table.
// A symbol reaches the output one symbol late (it waits to learn whether it ends the byte);
// a stalled output word holds the walk. No new word is taken until a decode word's walk is done.
// Synchronous reset puts the walk at the root; the node table is undefined until written.
module huffman_tree_decoder_top import hdec_pkg::*; (
  input logic        clk,
  input logic        rst,
  hdec_in_if.sink    req,
  hdec_out_if.source rsp
);

  logic               wr_en;
  logic [NODE_AW-1:0] wr_addr;
  node_t              wr_data;
  logic               rd_en;
  logic [NODE_AW-1:0] rd_addr;
  node_t              rd_data;
  logic               emit_free;
  emit_ctl_t          emit_ctl;

  hdec_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hdec_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .emit_free (emit_free),
    .emit_ctl  (emit_ctl)
  );

  hdec_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (emit_ctl),
    .emit_free (emit_free),
    .rsp       (rsp)
  );

endmodule

[hw/rtl/hdec_ram.sv]
`timescale 1ns / 1ps
module hdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/hdec_emit.sv]
`timescale 1ns / 1ps
module hdec_emit import hdec_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  emit_ctl_t ctl,
  output logic      emit_free,
  hdec_out_if.source rsp
);

  // One symbol is held back until we know whether it is the last of its byte.
  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             out_valid;
  logic [SYM_W-1:0] out_sym;
  logic             out_last;

  assign emit_free          = !out_valid || rsp.ready;
  assign rsp.valid          = out_valid;
  assign rsp.decoded_symbol = out_sym;
  assign rsp.last_of_byte   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // A push releases the held symbol as an inner one, a flush as the byte's last.
      if ((ctl.push || ctl.flush) && pend_valid) begin
        out_valid <= 1'b1;
        out_sym   <= pend_sym;
        out_last  <= ctl.flush;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        pend_sym   <= ctl.symbol;
        pend_valid <= 1'b1;
      end else if (ctl.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  a_push_flush_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.flush))
    else $error("push and flush requested together");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.push || ctl.flush) |-> emit_free)
    else $error("symbol moved while the output word is stalled");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> !pend_valid)
    else $error("pending symbol survived a flush");

endmodule

[hw/rtl/hdec_walk.sv]
`timescale 1ns / 1ps
module hdec_walk import hdec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  hdec_in_if.sink            req,
  output logic               wr_en,
  output logic [NODE_AW-1:0] wr_addr,
  output node_t              wr_data,
  output logic               rd_en,
  output logic [NODE_AW-1:0] rd_addr,
  input  node_t              rd_data,
  input  logic               emit_free,
  output emit_ctl_t          emit_ctl
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  pos, pos_next;
  node_t             cur, cur_next;
  node_t             root, root_next;
  logic [CODE_W-1:0] code, code_next;
  logic [BIT_W-1:0]  bit_cnt, bit_cnt_next;
  logic              last_byte, last_byte_next;

  logic [IDX_W-1:0]  child;
  logic              child_ok;
  logic              last_bit;
  logic              advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
    cur       <= cur_next;
    root      <= root_next;
    code      <= code_next;
    bit_cnt   <= bit_cnt_next;
    last_byte <= last_byte_next;
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    cur_next       = cur;
    root_next      = root;
    code_next      = code;
    bit_cnt_next   = bit_cnt;
    last_byte_next = last_byte;
    advance        = 1'b0;

    // The shared step unit: child select and range check of the current node.
    child    = code[TOP_BIT] ? cur.right : cur.left;
    child_ok = 32'(child) < NODE_COUNT;
    last_bit = bit_cnt == BIT_W'(CODE_W - 1);

    req.ready = (state == ST_IDLE);
    wr_en     = 1'b0;
    wr_addr   = NODE_AW'(req.node_index);
    wr_data   = '{leaf: req.leaf_flag, left: req.left_child,
                  right: req.right_child, symbol: req.symbol_value};
    rd_en     = 1'b0;
    rd_addr   = NODE_AW'(child);
    emit_ctl  = '0;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_DECODE) begin
            code_next      = req.code_byte;
            last_byte_next = req.final_byte;
            bit_cnt_next   = '0;
            state_next     = ST_STEP;
          end else if (32'(req.node_index) < NODE_COUNT) begin
            wr_en = 1'b1;
            // Keep the cached copies of the root and current node coherent.
            if (req.node_index == pos) begin
              cur_next = wr_data;
            end
            if (req.node_index == '0) begin
              root_next = wr_data;
            end
          end
        end
      end
      ST_STEP: begin
        if (child_ok) begin
          rd_en      = 1'b1;
          pos_next   = child;
          state_next = ST_LOOK;
        end else begin
          pos_next = '0;
          cur_next = root;
          advance  = 1'b1;
        end
      end
      ST_LOOK: begin
        if (rd_data.leaf) begin
          if (emit_free) begin
            emit_ctl.push   = 1'b1;
            emit_ctl.symbol = rd_data.symbol;
            pos_next        = '0;
            cur_next        = root;
            advance         = 1'b1;
          end
        end else begin
          cur_next = rd_data;
          advance  = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (emit_free) begin
          emit_ctl.flush = 1'b1;
          if (last_byte) begin
            pos_next = '0;
            cur_next = root;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (advance) begin
      code_next = code << 1;
      if (last_bit) begin
        state_next = ST_FLUSH;
      end else begin
        bit_cnt_next = bit_cnt + 1'b1;
        state_next   = ST_STEP;
      end
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < NODE_COUNT)
    else $error("walk position outside the node table");

  a_read_then_look: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == ST_LOOK)
    else $error("table read not followed by a leaf check");

  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_IDLE && req.command == CMD_WRITE)
    else $error("node write outside idle");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    emit_ctl.flush |=> state == ST_IDLE)
    else $error("byte end did not return to idle");

endmodule

[bench/huffman_decode_checker.sv]
`timescale 1ns / 1ps
module huffman_decode_checker import hdec_pkg::*; (
  input  logic clk,
  input  logic rst,
  hdec_in_if   req,
  hdec_out_if  rsp,
  output int   mismatches,
  output int   symbols_pending
);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_word_t;

  node_t            node_mirror [NODE_COUNT];
  logic [IDX_W-1:0] walk_pos;
  symbol_word_t     expected_symbols [$];

  // Walks one code byte through the mirrored tree and queues the symbols it yields.
  function automatic void walk_code_byte(input logic [CODE_W-1:0] code, input logic fin);
    symbol_word_t     found [$];
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] nxt;
    pos = walk_pos;
    for (int b = TOP_BIT; b >= 0; b--) begin
      nxt = code[b] ? node_mirror[pos].right : node_mirror[pos].left;
      if (int'(nxt) >= NODE_COUNT) begin
        pos = '0;
      end else begin
        pos = nxt;
        if (node_mirror[pos].leaf) begin
          found.push_back('{symbol: node_mirror[pos].symbol, last: 1'b0});
          pos = '0;
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_symbols.push_back(found[i]);
    if (fin) pos = '0;
    walk_pos = pos;
  endfunction

  always @(posedge clk) begin
    symbol_word_t want;
    if (rst) begin
      walk_pos = '0;
      expected_symbols.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (req.command == CMD_WRITE) begin
          if (int'(req.node_index) < NODE_COUNT)
            node_mirror[req.node_index] = '{leaf: req.leaf_flag, left: req.left_child,
                                             right: req.right_child, symbol: req.symbol_value};
        end else begin
          walk_code_byte(req.code_byte, req.final_byte);
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_symbols.size() == 0) begin
          $error("decoded_symbol: no word expected, got %0h (last_of_byte %0b)",
                 rsp.decoded_symbol, rsp.last_of_byte);
          mismatches++;
        end else begin
          want = expected_symbols.pop_front();
          if (rsp.decoded_symbol !== want.symbol) begin
            $error("decoded_symbol: expected %0h, got %0h", want.symbol, rsp.decoded_symbol);
            mismatches++;
          end
          if (rsp.last_of_byte !== want.last) begin
            $error("last_of_byte: expected %0b, got %0b", want.last, rsp.last_of_byte);
            mismatches++;
          end
        end
      end
    end
    symbols_pending = expected_symbols.size();
  end

endmodule

[bench/huffman_tree_decoder_top_tb.sv]
`timescale 1ns / 1ps
module huffman_tree_decoder_top_tb import hdec_pkg::*; ();

  logic clk;
  logic rst;

  hdec_in_if  req_if ();
  hdec_out_if rsp_if ();

  int mismatches;
  int symbols_pending;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int words_sent = 0;

  // Every written entry has children that were written before it or are the entry itself,
  // so no walk can ever reach an entry that holds nothing.
  logic [NODE_COUNT-1:0] written_map = '0;
  logic [IDX_W-1:0]      written_list [$];

  huffman_tree_decoder_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  huffman_decode_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_if),
    .rsp             (rsp_if),
    .mismatches      (mismatches),
    .symbols_pending (symbols_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("huffman_tree_decoder_top_tb: done, errors");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_cnt;
    bit hold_served;
    hold_cnt = 0;
    hold_served = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_cnt = 400;
        hold_served = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                           input logic leaf, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic fin);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.node_index   <= idx;
    req_if.left_child   <= lc;
    req_if.right_child  <= rc;
    req_if.leaf_flag    <= leaf;
    req_if.symbol_value <= sym;
    req_if.code_byte    <= code;
    req_if.final_byte   <= fin;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, input logic leaf,
                            input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                            input logic [SYM_W-1:0] sym);
    send_word(CMD_WRITE, idx, lc, rc, leaf, sym, CODE_W'($urandom_range(255)),
              1'($urandom_range(1)));
    if (!written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic decode_byte(input logic [CODE_W-1:0] code, input logic fin);
    send_word(CMD_DECODE, IDX_W'($urandom_range(511)), IDX_W'($urandom_range(511)),
              IDX_W'($urandom_range(511)), 1'($urandom_range(1)),
              SYM_W'($urandom_range(255)), code, fin);
  endtask

  function automatic logic [IDX_W-1:0] pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] fresh_index(inout logic [NODE_COUNT-1:0] taken);
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom_range(1, NODE_COUNT - 1)); while (taken[idx]);
    taken[idx] = 1'b1;
    return idx;
  endfunction

  // Builds a random full tree bottom-up, so each node is written after its children
  // and the root at entry 0 goes last.
  task automatic build_tree(input int leaves);
    logic [IDX_W-1:0]      pool [$];
    logic [IDX_W-1:0]      a;
    logic [IDX_W-1:0]      c;
    logic [IDX_W-1:0]      parent;
    logic [NODE_COUNT-1:0] taken;
    int                    i;
    taken = '0;
    taken[0] = 1'b1;
    for (i = 0; i < leaves; i++) begin
      parent = fresh_index(taken);
      write_node(parent, 1'b1, pick_written(), pick_written(), SYM_W'($urandom_range(255)));
      pool.push_back(parent);
    end
    while (pool.size() > 1) begin
      i = $urandom_range(pool.size() - 1);
      a = pool[i];
      pool.delete(i);
      i = $urandom_range(pool.size() - 1);
      c = pool[i];
      pool.delete(i);
      parent = (pool.size() == 0) ? '0 : fresh_index(taken);
      write_node(parent, 1'b0, a, c, SYM_W'($urandom_range(255)));
      pool.push_back(parent);
    end
  endtask

  initial begin
    int               goal;
    int               nbytes;
    int               r;
    logic [IDX_W-1:0] idx;
    rst = 1'b1;
    req_if.valid        = 1'b0;
    req_if.command      = CMD_WRITE;
    req_if.node_index   = '0;
    req_if.left_child   = '0;
    req_if.right_child  = '0;
    req_if.leaf_flag    = 1'b0;
    req_if.symbol_value = '0;
    req_if.code_byte    = '0;
    req_if.final_byte   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two leaves at the ends of the table under the root: every bit gives a symbol.
    write_node(9'd1, 1'b1, 9'd1, 9'd1, 8'h00);
    write_node(9'd511, 1'b1, 9'd511, 9'd511, 8'hFF);
    write_node(9'd0, 1'b0, 9'd1, 9'd511, 8'h00);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'hFF, 1'b1);
    decode_byte(8'hA5, 1'b0);
    // Two-level left branch: the walk carries an open code into the next byte.
    write_node(9'd256, 1'b0, 9'd1, 9'd511, 8'h11);
    write_node(9'd0, 1'b0, 9'd256, 9'd511, 8'h22);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'h80, 1'b0);
    decode_byte(8'h7F, 1'b1);
    // A node that loops on a 1 bit: bytes with no symbol, and padding dropped on the last byte.
    write_node(9'd301, 1'b1, 9'd0, 9'd0, 8'h5A);
    write_node(9'd300, 1'b0, 9'd301, 9'd300, 8'h33);
    write_node(9'd0, 1'b0, 9'd1, 9'd300, 8'h44);
    decode_byte(8'hFF, 1'b0);
    decode_byte(8'h7F, 1'b1);
    decode_byte(8'hFF, 1'b1);
    decode_byte(8'h00, 1'b0);
    // The root itself marked as a leaf.
    write_node(9'd0, 1'b1, 9'd1, 9'd0, 8'h3C);
    decode_byte(8'h0F, 1'b0);
    decode_byte(8'h80, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 66;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 66;
        end
        default: begin
          sender_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      goal = words_sent + 62;
      if (p == 0) begin
        // The output is held off while code bytes keep coming, so the input backs up.
        build_tree(6);
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) decode_byte(CODE_W'($urandom_range(255)), 1'b0);
        decode_byte(CODE_W'($urandom_range(255)), 1'b1);
      end
      while (words_sent < goal) begin
        r = $urandom_range(99);
        if (r < 75) begin
          build_tree($urandom_range(2, 9));
          nbytes = $urandom_range(2, 8);
          for (int k = 0; k < nbytes; k++)
            decode_byte(CODE_W'($urandom_range(255)),
                        (k == nbytes - 1) && ($urandom_range(4) != 0));
        end else if (r < 88) begin
          idx = IDX_W'($urandom_range(511));
          write_node(idx, 1'($urandom_range(1)),
                     ($urandom_range(3) == 0) ? idx : pick_written(),
                     ($urandom_range(3) == 0) ? idx : pick_written(),
                     SYM_W'($urandom_range(255)));
        end else begin
          decode_byte(CODE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (symbols_pending == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("huffman_tree_decoder_top_tb: done, clean");
    end else begin
      $display("huffman_tree_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/hdec_pkg.sv
hw/rtl/hdec_in_if.sv
hw/rtl/hdec_out_if.sv
hw/rtl/hdec_ram.sv
hw/rtl/hdec_emit.sv
hw/rtl/hdec_walk.sv
hw/rtl/huffman_tree_decoder_top.sv
bench/huffman_decode_checker.sv
bench/huffman_tree_decoder_top_tb.sv
